@@ hdl/matrix_multiply_4x4_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 matrix multiplier
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_4X4_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_MACROS_SVH

`ifndef SYNTHESIS
// Condition holds in every cycle out of reset.
`define MM4_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define MM4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MM4_ASSERT_ALWAYS(lbl, cond, msg)
`define MM4_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/mm4_pkg.sv @@
// ----------------------------------------------------------------------------
// mm4_pkg
// Types and constants shared by the matrix multiplier modules.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int DIM       = 4;
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;

  localparam int CELLS       = DIM * DIM;
  localparam int ROW_W       = $clog2(DIM);
  localparam int IDX_W       = $clog2(CELLS);
  localparam int PROD_W      = 2 * DATA_W;
  localparam int ACC_W       = PROD_W + $clog2(DIM);
  localparam int FIELD_IDX_W = 4;

  typedef enum logic [1:0] {
    REQ_LOAD_LEFT  = 2'd0,
    REQ_LOAD_RIGHT = 2'd1,
    REQ_COMPUTE    = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } seq_state_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [FIELD_IDX_W-1:0]   elem_index;
    logic signed [DATA_W-1:0] elem_value;
  } in_beat_t;

  typedef struct packed {
    logic [FIELD_IDX_W-1:0]   out_index;
    logic signed [DATA_W-1:0] out_value;
    logic                     out_last;
  } out_beat_t;

  // One product element travelling down the chain.
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col;
    logic [IDX_W-1:0] idx;
    logic             last;
  } tok_t;

  // Store write into one cell.
  typedef struct packed {
    logic                     left_we;
    logic                     right_we;
    logic [ROW_W-1:0]         addr;
    logic signed [DATA_W-1:0] data;
  } wr_t;

  typedef struct packed {
    tok_t tok;
    logic busy;
  } seq_stat_t;

endpackage

@@ hdl/mm4_cell.sv @@
// ----------------------------------------------------------------------------
// mm4_cell
// One multiply-accumulate cell: holds column k of the left matrix and row k
// of the right matrix, adds its product term to the passing partial sum.
// ----------------------------------------------------------------------------
module mm4_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  mm4_pkg::wr_t                 wr_i,
  input  mm4_pkg::tok_t                tok_i,
  input  logic signed [mm4_pkg::ACC_W-1:0] sum_i,
  output mm4_pkg::tok_t                tok_o,
  output logic signed [mm4_pkg::ACC_W-1:0] sum_o
);
  import mm4_pkg::*;

  logic signed [DATA_W-1:0] left_q  [DIM];
  logic signed [DATA_W-1:0] right_q [DIM];

  logic signed [DATA_W-1:0] l_sel, r_sel;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  sum_mid_q, sum_out_q, sum_out_d;
  tok_t                     tok_mid_q, tok_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < DIM; e++) begin
        left_q[e]  <= '0;
        right_q[e] <= '0;
      end
    end else begin
      if (wr_i.left_we) begin
        left_q[wr_i.addr] <= wr_i.data;
      end
      if (wr_i.right_we) begin
        right_q[wr_i.addr] <= wr_i.data;
      end
    end
  end

  assign l_sel     = left_q[tok_i.row];
  assign r_sel     = right_q[tok_i.col];
  assign prod_d    = l_sel * r_sel;
  assign sum_out_d = sum_mid_q + ACC_W'(prod_q);

  // Stage one: multiply; stage two: add into the partial sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_mid_q <= '0;
      tok_out_q <= '0;
    end else if (en_i) begin
      tok_mid_q <= tok_i;
      tok_out_q <= tok_mid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_mid_q <= sum_i;
      prod_q    <= prod_d;
      sum_out_q <= sum_out_d;
    end
  end

  assign tok_o = tok_out_q;
  assign sum_o = sum_out_q;

endmodule

@@ hdl/mm4_seq.sv @@
// ----------------------------------------------------------------------------
// mm4_seq
// Sequencer: on a compute request, feeds the sixteen element positions into
// the head of the cell chain, then waits for the last result beat.
// ----------------------------------------------------------------------------
module mm4_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               start_i,
  input  logic               done_i,
  output mm4_pkg::seq_stat_t stat_o
);
  import mm4_pkg::*;

  seq_state_e       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             cnt_last;

  assign cnt_last = (cnt_q == IDX_W'(CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    stat_o.tok.valid = 1'b0;
    stat_o.tok.idx   = cnt_q;
    stat_o.tok.row   = cnt_q[ROW_W-1:0];
    stat_o.tok.col   = cnt_q[IDX_W-1:ROW_W];
    stat_o.tok.last  = cnt_last;
    stat_o.busy      = 1'b1;
    case (state_q)
      ST_IDLE: begin
        stat_o.busy = 1'b0;
        cnt_d       = '0;
        if (start_i) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        stat_o.tok.valid = 1'b1;
        if (en_i) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (done_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/mm4_out.sv @@
// ----------------------------------------------------------------------------
// mm4_out
// Output stage: drops the fraction bits, saturates to the data width and
// holds the result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module mm4_out (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  mm4_pkg::tok_t                    tok_i,
  input  logic signed [mm4_pkg::ACC_W-1:0] sum_i,
  output logic                             valid_o,
  output mm4_pkg::out_beat_t               beat_o
);
  import mm4_pkg::*;

  localparam logic signed [DATA_W-1:0] MaxVal = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] MinVal = {1'b1, {(DATA_W-1){1'b0}}};

  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-DATA_W:0]     upper;
  logic                      fits;
  logic signed [DATA_W-1:0]  sat;
  logic                      valid_q;
  out_beat_t                 beat_q;

  assign shifted = sum_i >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:DATA_W-1];
  assign fits    = (&upper) || !(|upper);
  assign sat     = fits ? shifted[DATA_W-1:0] : (sum_i[ACC_W-1] ? MinVal : MaxVal);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q.out_index <= FIELD_IDX_W'(tok_i.idx);
      beat_q.out_value <= sat;
      beat_q.out_last  <= tok_i.last;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

@@ hdl/matrix_multiply_4x4.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// 4x4 signed Q16.16 matrix multiplier built as a chain of four MAC cells.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i / in_stall_o in_data_i  (in_beat_t)
//   out      source     out_valid_o / out_stall_i out_data_o (out_beat_t)
//
// A load beat is accepted whenever no compute is running.
// A compute beat streams one element position per cycle into the chain while
// the output is not stalled; each cell registers a multiply and then an add,
// and the 16 results leave the output stage one per cycle, again only while
// the output is not stalled.
// The input stalls from the compute beat until the last result beat is taken.
// An output stall freezes the whole chain. Reset clears both stores at once.
// ----------------------------------------------------------------------------
`include "matrix_multiply_4x4_macros.svh"

module matrix_multiply_4x4 (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mm4_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mm4_pkg::out_beat_t out_data_o
);
  import mm4_pkg::*;

  logic                    en;
  logic                    in_fire, out_fire, start, done, load_ok;
  logic [IDX_W-1:0]        widx;
  seq_stat_t               stat;
  tok_t                    tok_c [DIM+1];
  logic signed [ACC_W-1:0] sum_c [DIM+1];
  wr_t                     wr_c  [DIM];

  // Advance the chain unless a held result is stalled.
  assign en       = !out_valid_o || !out_stall_i;
  assign in_stall_o = stat.busy;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign start    = in_fire && (in_data_i.req_type == REQ_COMPUTE);
  assign done     = out_fire && out_data_o.out_last;
  assign widx     = IDX_W'(in_data_i.elem_index);
  assign load_ok  = in_fire && (32'(in_data_i.elem_index) < CELLS);

  mm4_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .start_i (start),
    .done_i  (done),
    .stat_o  (stat)
  );

  assign tok_c[0] = stat.tok;
  assign sum_c[0] = '0;

  for (genvar c = 0; c < DIM; c++) begin : g_cell
    // Left element (row, col) lives in cell col; right element (row, col) in cell row.
    always_comb begin
      wr_c[c].left_we  = load_ok && (in_data_i.req_type == REQ_LOAD_LEFT) &&
                         (widx[IDX_W-1:ROW_W] == ROW_W'(c));
      wr_c[c].right_we = load_ok && (in_data_i.req_type == REQ_LOAD_RIGHT) &&
                         (widx[ROW_W-1:0] == ROW_W'(c));
      wr_c[c].addr     = (in_data_i.req_type == REQ_LOAD_LEFT) ?
                         widx[ROW_W-1:0] : widx[IDX_W-1:ROW_W];
      wr_c[c].data     = in_data_i.elem_value;
    end

    mm4_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .wr_i   (wr_c[c]),
      .tok_i  (tok_c[c]),
      .sum_i  (sum_c[c]),
      .tok_o  (tok_c[c+1]),
      .sum_o  (sum_c[c+1])
    );
  end

  mm4_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tok_i   (tok_c[DIM]),
    .sum_i   (sum_c[DIM]),
    .valid_o (out_valid_o),
    .beat_o  (out_data_o)
  );

  `MM4_ASSERT_ALWAYS(a_out_only_busy, !out_valid_o || stat.busy, "result beat outside a compute")
  `MM4_ASSERT_NEXT(a_last_ends, done, !stat.busy, "compute still busy after last beat")
  `MM4_ASSERT_NEXT(a_start_busy, start, stat.busy, "compute beat did not start sequencer")

endmodule
